// ===== sv/tmcw_pkg.sv =====
`timescale 1ns / 1ps

package tmcw_pkg;

   // Screen geometry and tab expansion
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 5;
   localparam int CELLS      = ROWS * COLUMNS;

   // Derived widths
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int TAB_W  = $clog2(TAB_SPACES + 1);

   // Fixed field widths of the channels
   localparam int CHAR_W = 8;
   localparam int RROW_W = 5;
   localparam int RCOL_W = 7;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;

   // Operation codes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Character codes and cell constants
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic                 valid;
      logic [POS_W-1:0]     pos;
      logic [CHAR_W-1:0]    cell_char;
      logic [CHAR_W-1:0]    cell_attr;
      logic                 scrolled;
   } res_type;

endpackage

// ===== sv/tmcw_screen.sv =====
`timescale 1ns / 1ps

module tmcw_screen (
   input  logic                         clock,
   input  logic                         we,
   input  logic                         re,
   input  logic [tmcw_pkg::ADDR_W-1:0]  addr,
   input  logic [tmcw_pkg::CELL_W-1:0]  wdata,
   output logic [tmcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tmcw_pkg::CELL_W-1:0] screen_mem_ff [tmcw_pkg::CELLS];
   logic [tmcw_pkg::CELL_W-1:0] rd_data_ff;

   // Write one cell
   always_ff @(posedge clock) begin
      if (we) begin
         screen_mem_ff[addr] <= wdata;
      end
   end

   // Read one cell, data registered
   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= screen_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tmcw_seq.sv =====
`timescale 1ns / 1ps

module tmcw_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_op,
   input  logic [tmcw_pkg::CHAR_W-1:0]   req_char,
   input  logic [tmcw_pkg::CHAR_W-1:0]   req_attr,
   input  logic [tmcw_pkg::RROW_W-1:0]   req_row,
   input  logic [tmcw_pkg::RCOL_W-1:0]   req_col,
   input  logic                          res_ready,
   output tmcw_pkg::res_type             res,
   output logic                          mem_we,
   output logic                          mem_re,
   output logic [tmcw_pkg::ADDR_W-1:0]   mem_addr,
   output logic [tmcw_pkg::CELL_W-1:0]   mem_wdata,
   input  logic [tmcw_pkg::CELL_W-1:0]   mem_rdata
);

   localparam int ROW_W  = tmcw_pkg::ROW_W;
   localparam int COL_W  = tmcw_pkg::COL_W;
   localparam int ADDR_W = tmcw_pkg::ADDR_W;
   localparam int TAB_W  = tmcw_pkg::TAB_W;

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(tmcw_pkg::ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(tmcw_pkg::COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tmcw_pkg::CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_END   = ADDR_W'(tmcw_pkg::COLUMNS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EMIT   = 3'd2;
   localparam logic [2:0] ST_ROWCLR = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]                      state_ff,    state_in;
   logic [ROW_W-1:0]                top_ff,      top_in;
   logic [ROW_W-1:0]                row_ff,      row_in;
   logic [COL_W-1:0]                col_ff,      col_in;
   logic [ADDR_W-1:0]               cnt_ff,      cnt_in;
   logic [ADDR_W-1:0]               clr_base_ff, clr_base_in;
   logic [TAB_W-1:0]                tab_left_ff, tab_left_in;
   logic                            scr_ff,      scr_in;
   logic [tmcw_pkg::CHAR_W-1:0]     ch_ff,       ch_in;
   logic [tmcw_pkg::CHAR_W-1:0]     attr_ff,     attr_in;
   logic [tmcw_pkg::CELL_W-1:0]     cell_ff,     cell_in;

   logic                            finish;
   logic                            scroll;
   logic                            in_range;
   logic [tmcw_pkg::CHAR_W-1:0]     eff_ch;
   logic [tmcw_pkg::CHAR_W-1:0]     eff_attr;
   logic [ROW_W-1:0]                bs_row;
   logic [COL_W-1:0]                bs_col;
   logic [ADDR_W-1:0]               pos_cell;

   // Map a logical row and column to a physical cell address
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] top,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ROW_W:0]   sum;
      logic [ROW_W-1:0] prow;
      sum = (ROW_W+1)'(top) + (ROW_W+1)'(row);
      if (sum >= (ROW_W+1)'(tmcw_pkg::ROWS)) begin
         sum = sum - (ROW_W+1)'(tmcw_pkg::ROWS);
      end
      prow = sum[ROW_W-1:0];
      return ADDR_W'(prow) * ADDR_W'(tmcw_pkg::COLUMNS) + ADDR_W'(col);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign in_range   = (32'(req_row) < tmcw_pkg::ROWS) && (32'(req_col) < tmcw_pkg::COLUMNS);

   // Backspace target: one cell back, wrapping to the end of the previous row
   always_comb begin
      if (col_ff == '0) begin
         bs_row = row_ff - ROW_W'(1);
         bs_col = LAST_COL;
      end else begin
         bs_row = row_ff;
         bs_col = col_ff - COL_W'(1);
      end
   end

   // Tab expands into spaces with the default attribute
   assign eff_ch   = (tab_left_ff != '0) ? tmcw_pkg::CH_SPACE : ch_ff;
   assign eff_attr = (tab_left_ff != '0) ? tmcw_pkg::DEFAULT_ATTR : attr_ff;

   // Sequence: reset sweep, accept, emit, row clear, read, deliver
   always_comb begin
      state_in    = state_ff;
      top_in      = top_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cnt_in      = cnt_ff;
      clr_base_in = clr_base_ff;
      tab_left_in = tab_left_ff;
      scr_in      = scr_ff;
      ch_in       = ch_ff;
      attr_in     = attr_ff;
      cell_in     = cell_ff;
      finish      = 1'b0;
      scroll      = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = tmcw_pkg::BLANK_CELL;

      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = cnt_ff;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               scr_in  = 1'b0;
               cell_in = '0;
               if (req_op == tmcw_pkg::OP_READ) begin
                  tab_left_in = '0;
                  if (in_range) begin
                     mem_re   = 1'b1;
                     mem_addr = phys_addr(top_ff, ROW_W'(req_row), COL_W'(req_col));
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  ch_in       = req_char;
                  attr_in     = (req_attr == '0) ? tmcw_pkg::DEFAULT_ATTR : req_attr;
                  tab_left_in = (req_char == tmcw_pkg::CH_TAB) ?
                                TAB_W'(tmcw_pkg::TAB_SPACES) : '0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_READ: begin
            cell_in = mem_rdata;
            finish  = 1'b1;
         end
         ST_EMIT: begin
            if (tab_left_ff != '0) begin
               tab_left_in = tab_left_ff - TAB_W'(1);
            end
            case (eff_ch)
               tmcw_pkg::CH_BACKSPACE: begin
                  if (row_ff != '0 || col_ff != '0) begin
                     row_in    = bs_row;
                     col_in    = bs_col;
                     mem_we    = 1'b1;
                     mem_addr  = phys_addr(top_ff, bs_row, bs_col);
                     mem_wdata = {eff_attr, tmcw_pkg::CH_SPACE};
                  end
               end
               tmcw_pkg::CH_NEWLINE: begin
                  col_in = '0;
                  if (row_ff == LAST_ROW) begin
                     scroll = 1'b1;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end
               tmcw_pkg::CH_RETURN: begin
                  col_in = '0;
               end
               default: begin
                  mem_we    = 1'b1;
                  mem_addr  = phys_addr(top_ff, row_ff, col_ff);
                  mem_wdata = {eff_attr, eff_ch};
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        scroll = 1'b1;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            endcase
            if (scroll) begin
               scr_in      = 1'b1;
               clr_base_in = ADDR_W'(top_ff) * ADDR_W'(tmcw_pkg::COLUMNS);
               top_in      = (top_ff == LAST_ROW) ? '0 : top_ff + ROW_W'(1);
               cnt_in      = '0;
               state_in    = ST_ROWCLR;
            end else if (tab_left_in == '0) begin
               finish = 1'b1;
            end
         end
         ST_ROWCLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_base_ff + cnt_ff;
            if (cnt_ff == ROW_END) begin
               cnt_in = '0;
               if (tab_left_ff != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Deliver the result, or hold it until the output register frees up
      if (finish) begin
         state_in = res_ready ? ST_IDLE : ST_DONE;
      end
   end

   assign pos_cell = ADDR_W'(row_in) * ADDR_W'(tmcw_pkg::COLUMNS) + ADDR_W'(col_in);

   always_comb begin
      res.valid     = finish && res_ready;
      res.pos       = tmcw_pkg::POS_W'(pos_cell);
      res.cell_char = cell_in[7:0];
      res.cell_attr = cell_in[15:8];
      res.scrolled  = scr_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         top_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         cnt_ff      <= '0;
         tab_left_ff <= '0;
         scr_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         top_ff      <= top_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         cnt_ff      <= cnt_in;
         tab_left_ff <= tab_left_in;
         scr_ff      <= scr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      clr_base_ff <= clr_base_in;
      ch_ff       <= ch_in;
      attr_ff     <= attr_in;
      cell_ff     <= cell_in;
   end

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (col_ff <= LAST_COL) && (top_ff <= LAST_ROW))
      else $error("cursor or top row offset out of range");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWCLR) |-> (row_ff == LAST_ROW))
      else $error("row clear while cursor is not on the last row");

   a_read_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(mem_re))
      else $error("read data used without a read issued");

   a_scr_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(scr_ff) |-> $past(state_ff == ST_IDLE && req_tvalid))
      else $error("scroll flag cleared outside of a transaction");

endmodule

// ===== sv/text_mode_console_writer_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Ports                     Payload (lowest bit up)
// req      in   req_tvalid/tready/tdata   char_code, attribute, read_row, read_col
//                 /tuser                  tuser: operation
// rsp      out  rsp_tvalid/tready/tdata   cursor_position, cell_char,
//                                         cell_attribute, scrolled
//
// Plain put or read: at most one screen memory access per transaction.
// A scroll clears the new bottom row cell by cell through the single memory write
// port; a tab expands into spaces written one after another, plus their scrolls.
// After reset the screen memory is swept to blank cells, one cell per cycle,
// all ROWS*COLUMNS cells (2000) with req_tready low.
// A waiting result does not block a new transaction; the sequencer holds its own
// result until the output register frees up.
module text_mode_console_writer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code[7:0], attribute[15:8],
                                    // read_row[20:16], read_col[27:21], zero
   input  logic [0:0]  req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cursor_position[10:0], cell_char[18:11],
                                    // cell_attribute[26:19], scrolled[27], zero
);

   tmcw_pkg::res_type                res;
   logic                             res_ready;
   logic                             mem_we;
   logic                             mem_re;
   logic [tmcw_pkg::ADDR_W-1:0]      mem_addr;
   logic [tmcw_pkg::CELL_W-1:0]      mem_wdata;
   logic [tmcw_pkg::CELL_W-1:0]      mem_rdata;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [27:0]                      rsp_data_ff,  rsp_data_in;

   tmcw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .req_char   (req_tdata[7:0]),
      .req_attr   (req_tdata[15:8]),
      .req_row    (req_tdata[20:16]),
      .req_col    (req_tdata[27:21]),
      .res_ready  (res_ready),
      .res        (res),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   tmcw_screen u_screen (
      .clock   (clock),
      .we      (mem_we),
      .re      (mem_re),
      .addr    (mem_addr),
      .wdata   (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res.scrolled, res.cell_attr, res.cell_char, res.pos};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule
